// ===== src/hlsc_pkg.sv =====
// package: types, codes, constants and the transmit decision of the hdlc sequence control
`timescale 1ns / 1ps
package hlsc_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] PROBE_TIMEOUT_RESET   = 16'd500;
  localparam logic [7:0]  STATION_ADDRESS_RESET = 8'h30;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_TIMEOUT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDRESS = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_STOP    = 3'd1,
    OP_PAYLOAD = 3'd2,
    OP_TX_RDY  = 3'd3,
    OP_FRAME   = 3'd4,
    OP_TICK    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    RX_I      = 3'd0,
    RX_RR     = 3'd1,
    RX_RNR    = 3'd2,
    RX_REJ    = 3'd3,
    RX_SREJ   = 3'd4,
    RX_U_TEST = 3'd5,
    RX_U_OTH  = 3'd6
  } rx_kind_t;

  typedef enum logic [1:0] {
    TX_U_TEST = 2'd0,
    TX_I      = 2'd1,
    TX_RR     = 2'd2,
    TX_SREJ   = 2'd3
  } tx_kind_t;

  typedef enum logic [1:0] {
    PH_UNKNOWN = 2'd0,
    PH_PROBED  = 2'd1,
    PH_FOUND   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       rx_valid;
    logic [2:0] rx_type;
    logic       rx_has_payload;
    logic [2:0] rx_send_seq;
    logic [2:0] rx_recv_seq;
  } evt_t;

  typedef struct packed {
    logic       tx_valid;
    logic [1:0] tx_kind;
    logic [7:0] tx_address;
    logic [2:0] tx_send_seq;
    logic [2:0] tx_recv_seq;
    logic       tx_poll_final;
    logic       change_baud;
    logic       deliver_payload;
    logic [1:0] link_state;
    logic       queue_overflow;
  } res_t;

  typedef struct packed {
    logic [15:0] probe_timeout_ticks;
    logic [7:0]  station_address;
  } cfg_t;

  typedef struct packed {
    logic             running;
    logic             tx_idle;
    phase_t           phase;
    logic [2:0]       next_send_seq;
    logic [2:0]       expected_recv_seq;
    logic [2:0]       peer_ack_seq;
    logic             ack_pending;
    logic [2:0]       reject_first;
    logic [2:0]       reject_count;
    logic [CNT_W-1:0] payloads_waiting;
    logic [15:0]      probe_countdown;
  } link_t;

  localparam link_t LINK_RESET = '{
    running:           1'b0,
    tx_idle:           1'b1,
    phase:             PH_UNKNOWN,
    next_send_seq:     3'd0,
    expected_recv_seq: 3'd0,
    peer_ack_seq:      3'd0,
    ack_pending:       1'b0,
    reject_first:      3'd0,
    reject_count:      3'd0,
    payloads_waiting:  '0,
    probe_countdown:   16'd0
  };

  typedef struct packed {
    link_t st;
    res_t  res;
  } tx_pair_t;

  // at most one header: probe, then srej, then i, then rr
  function automatic tx_pair_t try_tx(link_t s, res_t r, cfg_t c);
    tx_pair_t p;
    logic     issued;
    p.st   = s;
    p.res  = r;
    issued = 1'b0;
    case (s.phase)
      PH_UNKNOWN: begin
        p.st.phase           = PH_PROBED;
        p.st.probe_countdown = c.probe_timeout_ticks;
        p.res.tx_kind        = TX_U_TEST;
        p.res.tx_poll_final  = 1'b1;
        issued               = 1'b1;
      end
      PH_FOUND: begin
        if (s.reject_count != 3'd0) begin
          p.res.tx_kind     = TX_SREJ;
          p.res.tx_recv_seq = s.reject_first;
          p.st.reject_first = s.reject_first + 3'd1;
          p.st.reject_count = s.reject_count - 3'd1;
          issued            = 1'b1;
        end else if (s.payloads_waiting != '0) begin
          p.res.tx_kind         = TX_I;
          p.res.tx_send_seq     = s.next_send_seq;
          p.res.tx_recv_seq     = s.expected_recv_seq;
          p.st.payloads_waiting = s.payloads_waiting - CNT_W'(1);
          p.st.ack_pending      = 1'b0;
          p.st.next_send_seq    = s.next_send_seq + 3'd1;
          issued                = 1'b1;
        end else if (s.ack_pending) begin
          p.res.tx_kind     = TX_RR;
          p.res.tx_recv_seq = s.expected_recv_seq;
          p.st.ack_pending  = 1'b0;
          issued            = 1'b1;
        end
      end
      default: begin
        issued = 1'b0;
      end
    endcase
    if (issued) begin
      p.st.tx_idle     = 1'b0;
      p.res.tx_valid   = 1'b1;
      p.res.tx_address = c.station_address;
    end
    return p;
  endfunction

endpackage

// ===== src/hlsc_if.sv =====
// interfaces: event, result and configuration channels
`timescale 1ns / 1ps
interface hlsc_evt_if;
  logic           valid;
  logic           ready;
  hlsc_pkg::evt_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hlsc_res_if;
  logic           valid;
  logic           ready;
  hlsc_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hlsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hlsc_pkg::CFG_IDX_W-1:0]  addr;
  logic [hlsc_pkg::CFG_DATA_W-1:0] wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== src/hlsc_cfg_regs.sv =====
// configuration registers: probe timeout and station address
`timescale 1ns / 1ps
module hlsc_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  hlsc_cfg_if.sink       cfg,
  output hlsc_pkg::cfg_t regs
);
  import hlsc_pkg::*;

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.probe_timeout_ticks <= PROBE_TIMEOUT_RESET;
      regs.station_address     <= STATION_ADDRESS_RESET;
    end else if (wr) begin
      case (cfg.addr)
        REG_PROBE_TIMEOUT:   regs.probe_timeout_ticks <= cfg.wdata[15:0];
        REG_STATION_ADDRESS: regs.station_address     <= cfg.wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/hlsc_step.sv =====
// per-item decision: next link state and the result item for one event
`timescale 1ns / 1ps
module hlsc_step (
  input  hlsc_pkg::evt_t  ev,
  input  hlsc_pkg::link_t st,
  input  hlsc_pkg::cfg_t  regs,
  output hlsc_pkg::link_t st_next,
  output hlsc_pkg::res_t  res_next
);
  import hlsc_pkg::*;

  always_comb begin
    link_t    s;
    res_t     r;
    tx_pair_t p;
    logic     frame_ok;
    s        = st;
    r        = '0;
    p        = '0;
    frame_ok = 1'b0;
    case (ev.opcode)
      OP_START: begin
        s         = LINK_RESET;
        s.running = 1'b1;
        p         = try_tx(s, r, regs);
        s         = p.st;
        r         = p.res;
      end
      OP_STOP: begin
        s = LINK_RESET;
      end
      OP_PAYLOAD: begin
        if (s.running) begin
          if (s.payloads_waiting >= CNT_W'(QUEUE_DEPTH)) begin
            r.queue_overflow = 1'b1;
          end else begin
            s.payloads_waiting = s.payloads_waiting + CNT_W'(1);
          end
          if (s.tx_idle) begin
            p = try_tx(s, r, regs);
            s = p.st;
            r = p.res;
          end
        end
      end
      OP_TX_RDY: begin
        if (s.running) begin
          s.tx_idle = 1'b1;
          p         = try_tx(s, r, regs);
          s         = p.st;
          r         = p.res;
        end
      end
      OP_FRAME: begin
        // before the baud is found only a test reply counts
        if (s.running && ev.rx_valid) begin
          if (s.phase == PH_FOUND) begin
            frame_ok = 1'b1;
          end else if (ev.rx_type == RX_U_TEST) begin
            frame_ok          = 1'b1;
            s.phase           = PH_FOUND;
            s.probe_countdown = 16'd0;
          end
        end
        if (frame_ok) begin
          if (ev.rx_has_payload) begin
            r.deliver_payload = 1'b1;
            if (ev.rx_type == RX_I) begin
              // out of order: reject the gap up to this frame
              if (s.expected_recv_seq != ev.rx_send_seq) begin
                s.reject_first = s.expected_recv_seq;
                s.reject_count = ev.rx_send_seq - s.expected_recv_seq;
              end
              s.ack_pending       = 1'b1;
              s.expected_recv_seq = ev.rx_send_seq + 3'd1;
            end
          end
          if (ev.rx_type == RX_I || ev.rx_type == RX_RR) begin
            s.peer_ack_seq = ev.rx_recv_seq;
          end
          if (s.tx_idle) begin
            p = try_tx(s, r, regs);
            s = p.st;
            r = p.res;
          end
        end
      end
      OP_TICK: begin
        if (s.running && s.phase == PH_PROBED) begin
          if (s.probe_countdown <= 16'd1) begin
            s.probe_countdown = 16'd0;
            s.phase           = PH_UNKNOWN;
            r.change_baud     = 1'b1;
            if (s.tx_idle) begin
              p = try_tx(s, r, regs);
              s = p.st;
              r = p.res;
            end
          end else begin
            s.probe_countdown = s.probe_countdown - 16'd1;
          end
        end
      end
      default: ;
    endcase
    r.link_state = s.phase;
    st_next      = s;
    res_next     = r;
  end

endmodule

// ===== src/hdlc_link_sequence_control_core.sv =====
// top level: input register, per-event decision, link state and result register
//
//   channel  dir  handshake      payload
//   evt      in   valid/ready    opcode, rx_valid, rx_type, rx_has_payload, rx_*_seq
//   res      out  valid/ready    tx_* header fields, change_baud, deliver_payload,
//                                link_state, queue_overflow
//   cfg      in   valid/ready    addr (0 probe timeout, 1 station address), wdata
//
// one item per cycle while res.ready holds, through input and result register
// the link state register is updated as an item moves from input to result register
// every event gives exactly one result item
// rst clears link state and both stage valids, registers return to 500 and 0x30
// a stalled result holds the result register and the input register behind it
`timescale 1ns / 1ps
module hdlc_link_sequence_control_core (
  input  logic      clk,
  input  logic      rst,
  hlsc_evt_if.sink  evt,
  hlsc_res_if.source res,
  hlsc_cfg_if.sink  cfg
);
  import hlsc_pkg::*;

  cfg_t  regs;
  link_t link;
  link_t link_next;
  evt_t  evt_q;
  logic  evt_vld;
  res_t  res_q;
  res_t  res_next;
  logic  res_vld;
  logic  advance;

  hlsc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  hlsc_step u_step (
    .ev       (evt_q),
    .st       (link),
    .regs     (regs),
    .st_next  (link_next),
    .res_next (res_next)
  );

  // stage handshake
  assign advance   = evt_vld && (!res_vld || res.ready);
  assign evt.ready = !evt_vld || advance;
  assign res.valid = res_vld;
  assign res.data  = res_q;

  // control and link state
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_vld <= 1'b0;
      res_vld <= 1'b0;
      link    <= LINK_RESET;
    end else begin
      if (evt.ready) begin
        evt_vld <= evt.valid;
      end
      if (advance) begin
        res_vld <= 1'b1;
        link    <= link_next;
      end else if (res.ready) begin
        res_vld <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      evt_q <= evt.data;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  // a header is only ever issued with the phase left at probed or found
  assert property (@(posedge clk) disable iff (rst)
    (res_vld && res_q.tx_valid) |-> (res_q.link_state != PH_UNKNOWN))
    else $error("header issued with baud unknown");

  // poll/final marks exactly the test probe
  assert property (@(posedge clk) disable iff (rst)
    (res_vld && res_q.tx_valid) |-> (res_q.tx_poll_final == (res_q.tx_kind == TX_U_TEST)))
    else $error("poll/final bit does not match frame kind");

  // a baud change can only be followed by a fresh probe
  assert property (@(posedge clk) disable iff (rst)
    (res_vld && res_q.change_baud && res_q.tx_valid) |-> (res_q.tx_kind == TX_U_TEST))
    else $error("non-probe header with baud change");

  // a stopped link holds nothing queued
  assert property (@(posedge clk) disable iff (rst)
    !link.running |-> (link.payloads_waiting == '0 && link.reject_count == 3'd0))
    else $error("stopped link holds queued work");

  // selective rejects only exist once the baud is found
  assert property (@(posedge clk) disable iff (rst)
    (link.reject_count != 3'd0) |-> (link.phase == PH_FOUND))
    else $error("reject range pending without baud");

endmodule

// ===== test/hlsc_link_checker.sv =====
// checker: watches the channels, predicts each result item of the hdlc link control and compares
`timescale 1ns / 1ps
module hlsc_link_checker (
  input  logic clk,
  input  logic rst,
  hlsc_evt_if  evt,
  hlsc_res_if  res,
  hlsc_cfg_if  cfg,
  output int   mismatches,
  output int   outstanding
);
  import hlsc_pkg::*;

  // register copies
  logic [15:0] timeout_ticks;
  logic [7:0]  own_address;

  // link state copies
  logic        link_up;
  logic        tx_free;
  phase_t      phase;
  logic [2:0]  send_seq;
  logic [2:0]  recv_seq;
  logic [2:0]  ack_seq;
  logic        ack_owed;
  logic [2:0]  srej_next;
  logic [2:0]  srej_left;
  int          queued;
  logic [15:0] probe_left;

  res_t want;
  res_t due;
  res_t got;
  res_t headers_due[$];

  function void link_down();
    link_up    = 1'b0;
    tx_free    = 1'b1;
    phase      = PH_UNKNOWN;
    send_seq   = 3'd0;
    recv_seq   = 3'd0;
    ack_seq    = 3'd0;
    ack_owed   = 1'b0;
    srej_next  = 3'd0;
    srej_left  = 3'd0;
    queued     = 0;
    probe_left = 16'd0;
  endfunction

  // one header at most: probe first, then srej, then i, then rr
  function void send_header();
    logic issued;
    issued = 1'b0;
    if (phase == PH_UNKNOWN) begin
      phase              = PH_PROBED;
      probe_left         = timeout_ticks;
      want.tx_kind       = TX_U_TEST;
      want.tx_poll_final = 1'b1;
      issued             = 1'b1;
    end else if (phase == PH_FOUND) begin
      if (srej_left != 3'd0) begin
        want.tx_kind     = TX_SREJ;
        want.tx_recv_seq = srej_next;
        srej_next        = srej_next + 3'd1;
        srej_left        = srej_left - 3'd1;
        issued           = 1'b1;
      end else if (queued != 0) begin
        want.tx_kind     = TX_I;
        want.tx_send_seq = send_seq;
        want.tx_recv_seq = recv_seq;
        queued--;
        ack_owed         = 1'b0;
        send_seq         = send_seq + 3'd1;
        issued           = 1'b1;
      end else if (ack_owed) begin
        want.tx_kind     = TX_RR;
        want.tx_recv_seq = recv_seq;
        ack_owed         = 1'b0;
        issued           = 1'b1;
      end
    end
    if (issued) begin
      tx_free         = 1'b0;
      want.tx_valid   = 1'b1;
      want.tx_address = own_address;
    end
  endfunction

  // received frame: only a valid probe reply counts until the baud is found
  function void take_frame(evt_t e);
    if (!e.rx_valid)
      return;
    if (phase != PH_FOUND) begin
      if (e.rx_type != RX_U_TEST)
        return;
      phase      = PH_FOUND;
      probe_left = 16'd0;
    end
    if (e.rx_has_payload) begin
      want.deliver_payload = 1'b1;
      if (e.rx_type == RX_I) begin
        // out of order: reject everything from the expected number up to this one
        if (recv_seq != e.rx_send_seq) begin
          srej_next = recv_seq;
          srej_left = e.rx_send_seq - recv_seq;
        end
        ack_owed = 1'b1;
        recv_seq = e.rx_send_seq + 3'd1;
      end
    end
    if (e.rx_type == RX_I || e.rx_type == RX_RR)
      ack_seq = e.rx_recv_seq;
    if (tx_free)
      send_header();
  endfunction

  // work out the result item of one event
  function void advance_link(evt_t e);
    want = '0;
    if (e.opcode == OP_START) begin
      link_down();
      link_up = 1'b1;
      send_header();
    end else if (e.opcode == OP_STOP) begin
      link_down();
    end else if (link_up) begin
      case (e.opcode)
        OP_PAYLOAD: begin
          if (queued >= QUEUE_DEPTH)
            want.queue_overflow = 1'b1;
          else
            queued++;
          if (tx_free)
            send_header();
        end
        OP_TX_RDY: begin
          tx_free = 1'b1;
          send_header();
        end
        OP_FRAME: begin
          take_frame(e);
        end
        OP_TICK: begin
          if (phase == PH_PROBED) begin
            if (probe_left <= 16'd1) begin
              probe_left       = 16'd0;
              phase            = PH_UNKNOWN;
              want.change_baud = 1'b1;
              if (tx_free)
                send_header();
            end else begin
              probe_left = probe_left - 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    want.link_state = phase;
  endfunction

  function void check_field(string label, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", label, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      timeout_ticks = PROBE_TIMEOUT_RESET;
      own_address   = STATION_ADDRESS_RESET;
      link_down();
      headers_due.delete();
      mismatches  = 0;
      outstanding <= 0;
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          REG_PROBE_TIMEOUT:   timeout_ticks = cfg.wdata;
          REG_STATION_ADDRESS: own_address   = cfg.wdata[7:0];
          default: begin
          end
        endcase
      end
      // result items against the oldest expectation
      if (res.valid && res.ready) begin
        got = res.data;
        if (headers_due.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatches++;
        end else begin
          due = headers_due[0];
          headers_due.delete(0);
          check_field("tx_valid", due.tx_valid, got.tx_valid);
          check_field("tx_kind", due.tx_kind, got.tx_kind);
          check_field("tx_address", due.tx_address, got.tx_address);
          check_field("tx_send_seq", due.tx_send_seq, got.tx_send_seq);
          check_field("tx_recv_seq", due.tx_recv_seq, got.tx_recv_seq);
          check_field("tx_poll_final", due.tx_poll_final, got.tx_poll_final);
          check_field("change_baud", due.change_baud, got.change_baud);
          check_field("deliver_payload", due.deliver_payload, got.deliver_payload);
          check_field("link_state", due.link_state, got.link_state);
          check_field("queue_overflow", due.queue_overflow, got.queue_overflow);
        end
      end
      // accepted events
      if (evt.valid && evt.ready) begin
        advance_link(evt.data);
        headers_due.push_back(want);
      end
      outstanding <= headers_due.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// testbench top: clock, reset, event and register stimulus for the hdlc link control, verdict
`timescale 1ns / 1ps
module tb;
  import hlsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SQUEEZE_CYCLES = 90;
  localparam int IDLE_PCT       = 38;

  // codes the block has no use for
  localparam logic [2:0] OP_SPARE_A   = 3'd6;
  localparam logic [2:0] OP_SPARE_B   = 3'd7;
  localparam logic [2:0] RX_UNDEFINED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(167);

  logic clk = 1'b0;
  logic rst = 1'b1;

  bit         calm;
  bit         squeeze;
  bit         squeeze_done;
  int         sent;
  int         quiet;
  int         mismatches;
  int         outstanding;
  logic [2:0] peer_seq;

  hlsc_evt_if evt_ch ();
  hlsc_res_if res_ch ();
  hlsc_cfg_if cfg_ch ();

  hdlc_link_sequence_control_core dut (
    .clk (clk),
    .rst (rst),
    .evt (evt_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  hlsc_link_checker link_chk (
    .clk         (clk),
    .rst         (rst),
    .evt         (evt_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  function automatic evt_t mk(logic [2:0] op, logic v = 1'b0, logic [2:0] kind = 3'd0,
                              logic pay = 1'b0, logic [2:0] s = 3'd0, logic [2:0] r = 3'd0);
    evt_t e;
    e.opcode         = op;
    e.rx_valid       = v;
    e.rx_type        = kind;
    e.rx_has_payload = pay;
    e.rx_send_seq    = s;
    e.rx_recv_seq    = r;
    return e;
  endfunction

  // offer one item, with a random gap before it unless calm
  task automatic put_event(input evt_t item);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.data  <= item;
    do @(posedge clk); while (evt_ch.ready !== 1'b1);
    sent++;
  endtask

  // stop offering, wait for every result, then let the pipeline empty
  task automatic settle();
    evt_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] ticks, input logic [15:0] addr_word,
                           input bit spare);
    logic [31:0] raw;
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= REG_PROBE_TIMEOUT;
    cfg_ch.wdata <= ticks;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.addr  <= REG_STATION_ADDRESS;
    cfg_ch.wdata <= addr_word;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (spare) begin
      raw = $urandom;
      cfg_ch.addr  <= REG_SPARE;
      cfg_ch.wdata <= raw[15:0];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // link traffic once the baud is found: payloads, tx ready, peer frames (mostly in order), ticks and spare codes
  function automatic evt_t rand_traffic();
    evt_t e;
    int   pick;
    int   kind_pick;
    e    = '0;
    pick = $urandom_range(99);
    if (pick < 22) begin
      e.opcode = OP_PAYLOAD;
    end else if (pick < 48) begin
      e.opcode = OP_TX_RDY;
    end else if (pick < 86) begin
      e.opcode   = OP_FRAME;
      e.rx_valid = ($urandom_range(99) < 92);
      kind_pick  = $urandom_range(99);
      if (kind_pick < 55)      e.rx_type = RX_I;
      else if (kind_pick < 68) e.rx_type = RX_RR;
      else if (kind_pick < 73) e.rx_type = RX_RNR;
      else if (kind_pick < 78) e.rx_type = RX_REJ;
      else if (kind_pick < 83) e.rx_type = RX_SREJ;
      else if (kind_pick < 91) e.rx_type = RX_U_TEST;
      else if (kind_pick < 97) e.rx_type = RX_U_OTH;
      else                     e.rx_type = RX_UNDEFINED;
      e.rx_has_payload = (e.rx_type == RX_I) ? ($urandom_range(99) < 85)
                                             : ($urandom_range(99) < 25);
      e.rx_send_seq = ($urandom_range(99) < 75) ? peer_seq : 3'($urandom);
      e.rx_recv_seq = 3'($urandom);
      if (e.rx_valid && e.rx_type == RX_I && e.rx_has_payload)
        peer_seq = e.rx_send_seq + 3'd1;
    end else if (pick < 97) begin
      e.opcode = OP_TICK;
    end else begin
      e.opcode = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    end
    return e;
  endfunction

  // start, a few probe-phase events, the test reply, then traffic, sometimes a stop
  task automatic link_session(input int len);
    put_event(mk(OP_START));
    peer_seq = 3'd0;
    repeat ($urandom_range(0, 3)) put_event(mk($urandom_range(1) ? OP_TICK : OP_TX_RDY));
    put_event(mk(OP_FRAME, 1'b1, RX_U_TEST, 1'($urandom), 3'($urandom), 3'($urandom)));
    repeat (len) put_event(rand_traffic());
    if ($urandom_range(1))
      put_event(mk(OP_STOP));
  endtask

  task automatic random_phase(input int goal);
    logic [31:0] raw;
    while (sent < goal) begin
      if ($urandom_range(99) < 15) begin
        // fully random items, start and stop among them
        repeat ($urandom_range(4, 12)) begin
          raw = $urandom;
          put_event(raw[$bits(evt_t)-1:0]);
        end
      end else begin
        link_session($urandom_range(10, 45));
      end
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    squeeze_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeeze_done) begin
        squeeze_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  initial begin
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    evt_ch.valid <= 1'b0;
    evt_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr  <= '0;
    cfg_ch.wdata <= '0;
    calm     = 1'b0;
    squeeze  = 1'b0;
    sent     = 0;
    peer_seq = 3'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset register values: idle link, probe, found, reject range, ack paths
    put_event(mk(OP_TICK));
    put_event(mk(OP_PAYLOAD));
    put_event(mk(OP_FRAME, 1'b1, RX_U_TEST, 1'b1));
    put_event(mk(OP_SPARE_A));
    put_event(mk(OP_SPARE_B, 1'b1, RX_UNDEFINED, 1'b1, 3'd7, 3'd7));
    put_event(mk(OP_START));
    put_event(mk(OP_FRAME, 1'b1, RX_I, 1'b1, 3'd0, 3'd0));
    put_event(mk(OP_FRAME, 1'b0, RX_U_TEST, 1'b1));
    put_event(mk(OP_TICK));
    put_event(mk(OP_FRAME, 1'b1, RX_U_TEST, 1'b1, 3'd7, 3'd7));
    put_event(mk(OP_PAYLOAD));
    put_event(mk(OP_FRAME, 1'b1, RX_I, 1'b1, 3'd0, 3'd7));
    put_event(mk(OP_FRAME, 1'b1, RX_I, 1'b1, 3'd5, 3'd0));
    repeat (6) put_event(mk(OP_TX_RDY));
    put_event(mk(OP_FRAME, 1'b1, RX_I, 1'b0, 3'd3, 3'd2));
    put_event(mk(OP_FRAME, 1'b1, RX_RR, 1'b0, 3'd0, 3'd5));
    put_event(mk(OP_FRAME, 1'b1, RX_RNR, 1'b0));
    put_event(mk(OP_FRAME, 1'b1, RX_REJ, 1'b0));
    put_event(mk(OP_FRAME, 1'b1, RX_SREJ, 1'b0));
    put_event(mk(OP_FRAME, 1'b1, RX_U_OTH, 1'b1));
    put_event(mk(OP_FRAME, 1'b1, RX_I, 1'b1, 3'd6, 3'd7));
    put_event(mk(OP_STOP));
    settle();

    // zero timeout: expiry with the transmitter busy and with it idle
    configure(16'd0, 16'h00FF, 1'b0);
    put_event(mk(OP_START));
    put_event(mk(OP_TICK));
    put_event(mk(OP_PAYLOAD));
    put_event(mk(OP_TX_RDY));
    put_event(mk(OP_TX_RDY));
    put_event(mk(OP_TICK));
    put_event(mk(OP_STOP));
    settle();

    // one-tick timeout, address zero, one long result hold-off
    configure(16'd1, 16'hC300, 1'b0);
    squeeze = 1'b1;
    random_phase(170);
    settle();

    // longest timeout, queue driven past capacity
    configure(16'hFFFF, 16'h5AA5, 1'b0);
    put_event(mk(OP_START));
    put_event(mk(OP_FRAME, 1'b1, RX_U_TEST, 1'b0));
    repeat (QUEUE_DEPTH + 6) put_event(mk(OP_PAYLOAD));
    repeat (4) put_event(mk(OP_TX_RDY));
    random_phase(450);
    settle();

    // no idling on either side
    configure(16'd3, 16'($urandom), 1'b0);
    calm = 1'b1;
    random_phase(520);
    settle();
    calm = 1'b0;

    configure(16'($urandom_range(2, 40)), 16'($urandom), 1'b1);
    random_phase(560);
    settle();

    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
